[src/np_pkg.sv]
// Shared constants for the next-permutation block.
package np_pkg;

    // Width of the active-count field on the input channel.
    localparam int COUNT_BITS = 4;

endpackage

[src/np_if.sv]
// Valid/ready channel interfaces for the next-permutation block.
interface np_in_if
    import np_pkg::*;
#(
    parameter int N = 8,
    parameter int W = 4
);
    logic                      valid;
    logic                      ready;
    logic [COUNT_BITS-1:0]     count;
    logic [N-1:0][W-1:0]       in_elem;

    modport source (output valid, output count, output in_elem, input ready);
    modport sink   (input valid, input count, input in_elem, output ready);
endinterface

interface np_out_if #(
    parameter int N = 8,
    parameter int W = 4
);
    logic                      valid;
    logic                      ready;
    logic [N-1:0][W-1:0]       out_elem;

    modport source (output valid, output out_elem, input ready);
    modport sink   (input valid, input out_elem, output ready);
endinterface

[src/np_high_bit.sv]
// Highest-set-bit finder used for pivot and swap-partner search.
module np_high_bit #(
    parameter int WIDTH    = 8,
    parameter int IDX_BITS = 3
) (
    input  logic [WIDTH-1:0]    i_bits,
    output logic [IDX_BITS-1:0] o_idx,
    output logic                o_found
);

    always_comb begin
        o_idx   = '0;
        o_found = 1'b0;
        for (int k = 0; k < WIDTH; k++) begin
            if (i_bits[k]) begin
                o_idx   = IDX_BITS'(k);
                o_found = 1'b1;
            end
        end
    end

endmodule

[src/next_permutation.sv]
// Top level: five-stage pipeline producing the next lexicographic permutation.
//
//  channel  | dir | payload                          | item
//  ---------+-----+----------------------------------+----------------------------
//  i_in     | in  | count, in_elem[MAX_ELEMENTS]     | sequence plus active count
//  o_out    | out | out_elem[MAX_ELEMENTS]           | next permutation
//
//  Accepts one item per cycle unless a stalled output has filled all stages.
//  Stages: ascents, pivot search, swap-partner search, swap, suffix reversal.
//  Each stage holds its item while the next one is full and stalled; empty
//  stages keep filling, so bubbles collapse under a stalled output.
//  Reset (i_rst_n low at a clock edge) empties all stages; data regs keep junk.
module next_permutation
    import np_pkg::*;
#(
    parameter int MAX_ELEMENTS = 8,
    parameter int ELEMENT_BITS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    np_in_if.sink      i_in,
    np_out_if.source   o_out
);

    localparam int N      = MAX_ELEMENTS;
    localparam int EB     = ELEMENT_BITS;
    localparam int IW     = $clog2(N);        // position index
    localparam int CW     = $clog2(N + 1);    // holds a count up to N
    localparam int STAGES = 5;

    typedef logic [N-1:0][EB-1:0] t_seq;

    // ---------------------------------------------------------------
    // Stage control: valid per stage, ready ripples back from output.
    // ---------------------------------------------------------------
    logic [STAGES:1] r_vld;
    logic [STAGES:1] rdy;

    always_comb begin
        rdy[STAGES] = !r_vld[STAGES] || o_out.ready;
        for (int s = STAGES - 1; s >= 1; s--) begin
            rdy[s] = !r_vld[s] || rdy[s+1];
        end
    end

    assign i_in.ready  = rdy[1];
    assign o_out.valid = r_vld[STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) r_vld[1] <= i_in.valid;
            for (int s = 2; s <= STAGES; s++) begin
                if (rdy[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: saturate count, mark ascents a[k] < a[k+1] inside count.
    // ---------------------------------------------------------------
    logic [CW-1:0] n_s1_n;
    logic [N-2:0]  n_s1_asc;
    t_seq          r_s1_v;
    logic [CW-1:0] r_s1_n;
    logic [N-2:0]  r_s1_asc;

    always_comb begin
        if (i_in.count > COUNT_BITS'(N)) begin
            n_s1_n = CW'(N);
        end else begin
            n_s1_n = i_in.count[CW-1:0];
        end
        for (int k = 0; k < N - 1; k++) begin
            n_s1_asc[k] = (CW'(k + 1) < n_s1_n) && (i_in.in_elem[k] < i_in.in_elem[k+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1_v   <= i_in.in_elem;
            r_s1_n   <= n_s1_n;
            r_s1_asc <= n_s1_asc;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: pivot = rightmost ascent; fetch its value.
    // ---------------------------------------------------------------
    logic [IW-1:0] n_s2_p;
    logic          n_s2_has;
    t_seq          r_s2_v;
    logic [CW-1:0] r_s2_n;
    logic [IW-1:0] r_s2_p;
    logic          r_s2_has;
    logic [EB-1:0] r_s2_pv;

    np_high_bit #(
        .WIDTH    (N - 1),
        .IDX_BITS (IW)
    ) u_pivot (
        .i_bits  (r_s1_asc),
        .o_idx   (n_s2_p),
        .o_found (n_s2_has)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_s2_v   <= r_s1_v;
            r_s2_n   <= r_s1_n;
            r_s2_p   <= n_s2_p;
            r_s2_has <= n_s2_has;
            r_s2_pv  <= r_s1_v[n_s2_p];
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: swap partner. The suffix past the pivot is non-increasing,
    // so the rightmost larger value is also the smallest larger one.
    // ---------------------------------------------------------------
    logic [N-1:0]  n_s3_gt;
    logic [IW-1:0] n_s3_pick;
    logic          n_s3_found;
    t_seq          r_s3_v;
    logic [CW-1:0] r_s3_n;
    logic [IW-1:0] r_s3_p;
    logic          r_s3_has;
    logic [IW-1:0] r_s3_pick;

    always_comb begin
        for (int j = 0; j < N; j++) begin
            n_s3_gt[j] = (IW'(j) > r_s2_p) && (CW'(j) < r_s2_n) && (r_s2_v[j] > r_s2_pv);
        end
    end

    np_high_bit #(
        .WIDTH    (N),
        .IDX_BITS (IW)
    ) u_pick (
        .i_bits  (n_s3_gt),
        .o_idx   (n_s3_pick),
        .o_found (n_s3_found)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s3_v    <= r_s2_v;
            r_s3_n    <= r_s2_n;
            r_s3_p    <= r_s2_p;
            r_s3_has  <= r_s2_has && n_s3_found;
            r_s3_pick <= n_s3_pick;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: swap; set the reversal span [lo, n) and its mirror sum.
    // No pivot means the whole active part is reversed.
    // ---------------------------------------------------------------
    t_seq          n_s4_w;
    logic [CW-1:0] n_s4_lo;
    logic [CW:0]   n_s4_ms;
    t_seq          r_s4_w;
    logic [CW-1:0] r_s4_lo;
    logic [CW-1:0] r_s4_n;
    logic [CW:0]   r_s4_ms;

    always_comb begin
        n_s4_w = r_s3_v;
        if (r_s3_has) begin
            n_s4_w[r_s3_p]    = r_s3_v[r_s3_pick];
            n_s4_w[r_s3_pick] = r_s3_v[r_s3_p];
            n_s4_lo           = CW'(r_s3_p) + CW'(1);
        end else begin
            n_s4_lo = '0;
        end
        // wraps for an empty span; positions are masked in that case
        n_s4_ms = {1'b0, n_s4_lo} + {1'b0, r_s3_n} - (CW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_s4_w  <= n_s4_w;
            r_s4_lo <= n_s4_lo;
            r_s4_n  <= r_s3_n;
            r_s4_ms <= n_s4_ms;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: reverse the span; everything else passes through.
    // ---------------------------------------------------------------
    logic [N-1:0][CW:0] n_s5_mir;
    t_seq               n_s5_out;
    t_seq               r_s5_out;

    always_comb begin
        for (int k = 0; k < N; k++) begin
            n_s5_mir[k] = r_s4_ms - (CW+1)'(k);
            if ((CW'(k) >= r_s4_lo) && (CW'(k) < r_s4_n)) begin
                n_s5_out[k] = r_s4_w[n_s5_mir[k][IW-1:0]];
            end else begin
                n_s5_out[k] = r_s4_w[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_s5_out <= n_s5_out;
        end
    end

    assign o_out.out_elem = r_s5_out;

`ifndef NO_ASSERTIONS
    // partner lies strictly right of the pivot
    a_pick_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && r_s3_has) |-> (r_s3_pick > r_s3_p))
        else $error("swap partner not right of pivot");

    // saturated count never exceeds the element count
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s1_n <= CW'(N)))
        else $error("active count above MAX_ELEMENTS");

    // a stalled stage keeps its item
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !rdy[3]) |=> (r_vld[2] && $stable(r_s2_p) && $stable(r_s2_pv)))
        else $error("stage 2 item lost under stall");

    // an empty first stage always takes an item
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[1] |-> i_in.ready)
        else $error("input blocked while first stage empty");

    // output stage loaded only from a valid stage 4
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld[4] && rdy[5]) |=> !r_vld[5])
        else $error("output valid without source item");
`endif

endmodule

[dv/perm_successor_check.sv]
// Scoreboard for next_permutation: predicts each successor sequence and compares results.
`timescale 1ns / 1ps

module perm_successor_check
    import np_pkg::*;
#(
    parameter int N = 8,
    parameter int W = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [COUNT_BITS-1:0]   i_count,
    input  logic [N-1:0][W-1:0]     i_in_elem,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [N-1:0][W-1:0]     i_out_elem,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef logic [N-1:0][W-1:0] t_seq;

    t_seq pending_successors[$];
    int   fail_total = 0;

    // Next lexicographic order of the first cnt values; the rest pass through.
    function automatic t_seq successor_of(input logic [COUNT_BITS-1:0] cnt, input t_seq a);
        t_seq         v;
        int           n;
        int           p;
        int           pivot;
        int           pick;
        int           lo;
        int           hi;
        logic [W-1:0] t;
        v = a;
        n = (cnt > N) ? N : int'(cnt);
        if (n >= 2) begin
            // p ends at the index just right of the rightmost ascent, or 0
            p = n - 1;
            for (int k = n - 1; k > 0; k--) begin
                if (v[k-1] < v[k]) break;
                p = k - 1;
            end
            lo = 0;
            if (p != 0) begin
                pivot = p - 1;
                pick  = p;
                // rightmost of the smallest values above the pivot
                for (int j = p + 1; j < n; j++) begin
                    if (v[j] > v[pivot] && v[j] <= v[pick]) pick = j;
                end
                t        = v[pivot];
                v[pivot] = v[pick];
                v[pick]  = t;
                lo       = p;
            end
            hi = n - 1;
            while (lo < hi) begin
                t     = v[lo];
                v[lo] = v[hi];
                v[hi] = t;
                lo++;
                hi--;
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_seq want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                pending_successors.push_back(successor_of(i_count, i_in_elem));
            if (i_out_valid && i_out_ready) begin
                if (pending_successors.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, i_out_elem);
                    fail_total++;
                end else begin
                    want = pending_successors.pop_front();
                    for (int k = 0; k < N; k++) begin
                        if (i_out_elem[k] !== want[k]) begin
                            $display("%0t: out_elem[%0d] expected %0d, got %0d",
                                     $time, k, want[k], i_out_elem[k]);
                            fail_total++;
                        end
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_successors.size();
    end

endmodule

[dv/next_permutation_tb.sv]
// Testbench top for next_permutation: stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 1ps

module next_permutation_tb;
    import np_pkg::*;

    localparam int N          = 8;
    localparam int W          = 4;
    localparam int RAND_ITEMS = 1150;
    // Must exceed the slowest legal item: longest send gap + longest stall + pipe.
    // Nothing accepted for this long means the block is hung.
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = 10;

    typedef logic [N-1:0][W-1:0] t_seq;

    logic i_clk;
    logic i_rst_n;

    np_in_if  #(.N(N), .W(W)) in_ch ();
    np_out_if #(.N(N), .W(W)) out_ch ();

    int fail_count;
    int pending;

    next_permutation #(
        .MAX_ELEMENTS (N),
        .ELEMENT_BITS (W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    perm_successor_check #(.N(N), .W(W)) scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_count      (in_ch.count),
        .i_in_elem    (in_ch.in_elem),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_elem   (out_ch.out_elem),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Idle draws. Each side flips in and out of a burst mode now and then;
    // in burst mode it never idles, otherwise it draws a random wait.
    // ------------------------------------------------------------------
    bit send_burst;
    bit recv_burst;

    function automatic int draw_wait(ref bit burst);
        if ($urandom_range(0, 39) == 0) burst = ~burst;
        return burst ? 0 : int'($urandom_range(0, 18));
    endfunction

    // ------------------------------------------------------------------
    // Output side: ready drops for a random number of cycles after each
    // accepted result, unless no wait is drawn. One NBA per edge on ready.
    // ------------------------------------------------------------------
    int recv_hold;

    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_hold    <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            stall = draw_wait(recv_burst);
            if (stall == 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b0;
                recv_hold    <= stall - 1;
            end
        end else if (!out_ch.ready) begin
            if (recv_hold == 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                recv_hold <= recv_hold - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles without any handshake on either channel.
    // ------------------------------------------------------------------
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("next_permutation_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Position 0 is the first entry of the list.
    function automatic t_seq to_seq(input int e [N]);
        t_seq v;
        for (int k = 0; k < N; k++) v[k] = W'(e[k]);
        return v;
    endfunction

    // Present one item, hold it until accepted, then maybe idle. valid stays
    // high straight into the next item when no gap is drawn.
    task automatic send_seq(input logic [COUNT_BITS-1:0] cnt, input t_seq v);
        int gap;
        in_ch.count   <= cnt;
        in_ch.in_elem <= v;
        in_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random sequence. Count is mostly in the useful 2..8 range, sometimes
    // anything the 4-bit field holds (0, 1 and saturating 9..15).
    // Shapes: distinct values, small alphabets with many repeats,
    // descending runs (no ascent or ascent only near the end), raw noise.
    task automatic send_random_seq();
        logic [COUNT_BITS-1:0] cnt;
        t_seq                  v;
        int                    pool [16];
        int                    n;
        int                    kind;
        int                    j;
        int                    t;
        int                    top;
        cnt  = ($urandom_range(0, 9) == 0) ? COUNT_BITS'($urandom_range(0, 15))
                                           : COUNT_BITS'($urandom_range(2, 8));
        n    = (cnt > N) ? N : int'(cnt);
        kind = int'($urandom_range(0, 9));
        for (int k = 0; k < N; k++) v[k] = W'($urandom_range(0, 15));
        if (kind < 4) begin
            for (int k = 0; k < 16; k++) pool[k] = k;
            for (int k = 15; k > 0; k--) begin
                j       = int'($urandom_range(0, k));
                t       = pool[k];
                pool[k] = pool[j];
                pool[j] = t;
            end
            for (int k = 0; k < N; k++) v[k] = W'(pool[k]);
        end else if (kind < 7) begin
            top = int'($urandom_range(1, 3));
            for (int k = 0; k < n; k++) v[k] = W'($urandom_range(0, top));
        end else if (kind < 9) begin
            // insertion sort of the active part, largest first
            for (int k = 1; k < n; k++) begin
                for (int i = k; i > 0 && v[i-1] < v[i]; i--) begin
                    t      = int'(v[i]);
                    v[i]   = v[i-1];
                    v[i-1] = W'(t);
                end
            end
            if (n >= 2 && $urandom_range(0, 1) == 1) begin
                j      = int'($urandom_range(n - 2 > 2 ? n - 3 : 0, n - 2));
                t      = int'(v[j]);
                v[j]   = v[j+1];
                v[j+1] = W'(t);
            end
        end
        send_seq(cnt, v);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.count    <= '0;
        in_ch.in_elem  <= '0;
        send_burst      = 1'b0;
        recv_burst      = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: short counts, ascending/descending/equal pairs,
        // the full descending wrap, constant runs at both value extremes,
        // repeated values around the swap partner, saturated counts and
        // junk sitting beyond the active part.
        send_seq(4'd0,  to_seq('{15, 0, 15, 0, 15, 0, 15, 0}));
        send_seq(4'd1,  to_seq('{9, 3, 2, 1, 0, 15, 14, 13}));
        send_seq(4'd2,  to_seq('{3, 7, 15, 15, 15, 15, 15, 15}));
        send_seq(4'd2,  to_seq('{5, 5, 0, 1, 2, 3, 4, 6}));
        send_seq(4'd2,  to_seq('{9, 4, 8, 8, 8, 8, 8, 8}));
        send_seq(4'd8,  to_seq('{0, 1, 2, 3, 4, 5, 6, 7}));
        send_seq(4'd8,  to_seq('{7, 6, 5, 4, 3, 2, 1, 0}));
        send_seq(4'd8,  to_seq('{15, 15, 15, 15, 15, 15, 15, 15}));
        send_seq(4'd8,  to_seq('{0, 0, 0, 0, 0, 0, 0, 0}));
        send_seq(4'd8,  to_seq('{15, 14, 13, 12, 11, 10, 9, 8}));
        send_seq(4'd4,  to_seq('{1, 2, 2, 0, 11, 12, 13, 14}));
        send_seq(4'd5,  to_seq('{2, 1, 3, 3, 2, 0, 0, 0}));
        send_seq(4'd3,  to_seq('{0, 2, 1, 5, 5, 5, 5, 5}));
        send_seq(4'd8,  to_seq('{7, 6, 5, 4, 3, 2, 0, 1}));
        send_seq(4'd9,  to_seq('{0, 1, 2, 3, 4, 5, 6, 7}));
        send_seq(4'd15, to_seq('{10, 9, 8, 7, 6, 5, 4, 3}));
        send_seq(4'd3,  to_seq('{1, 2, 3, 15, 15, 15, 15, 15}));
        send_seq(4'd6,  to_seq('{3, 1, 4, 1, 5, 9, 2, 6}));
        send_seq(4'd12, to_seq('{1, 1, 2, 2, 1, 1, 0, 0}));
        send_seq(4'd7,  to_seq('{0, 15, 0, 15, 0, 15, 0, 15}));
        send_seq(4'd8,  to_seq('{1, 3, 3, 3, 2, 2, 1, 0}));

        repeat (RAND_ITEMS) send_random_seq();

        in_ch.valid <= 1'b0;
        // Drain; the watchdog catches a block that never delivers.
        // One edge first so the count includes the last accepted item.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("next_permutation_tb: done, clean");
        end else begin
            $display("next_permutation_tb: done, errors");
        end
        $finish;
    end

endmodule
